// ===== rtl/lscm_pkg.sv =====
`default_nettype none
package lscm_pkg;

  localparam int DEF_TABLE_DEPTH   = 256;
  localparam int DEF_SAMPLE_WIDTH  = 32;
  localparam int DEF_LOG_FRAC_BITS = 16;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_RANGE_MIN   = 2'd0,
    REG_RANGE_MAX   = 2'd1,
    REG_COLOR_COUNT = 2'd2
  } cfg_reg_e;

  localparam logic [31:0] RST_RANGE_MIN   = 32'd1;
  localparam logic [31:0] RST_RANGE_MAX   = 32'd10;
  localparam logic [8:0]  RST_COLOR_COUNT = 9'd256;

endpackage
`default_nettype wire

// ===== rtl/lscm_ram.sv =====
`default_nettype none
module lscm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[addr_i];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/lscm_log.sv =====
`default_nettype none
module lscm_log #(
  parameter int LOG_FRAC_BITS = 16
) (
  input  wire logic                       clk_i,
  input  wire logic                       en_i,
  input  wire logic [31:0]                mag_i,
  output logic      [LOG_FRAC_BITS+4:0]   log_o
);

  import lscm_pkg::*;

  localparam int LF = LOG_FRAC_BITS;

  logic [31:0]   m_q;
  logic [4:0]    p_d;
  logic [4:0]    pa_q;
  logic [31:0]   y_q  [LF];
  logic [LF-1:0] bits_q [LF+1];
  logic [4:0]    pp_q [LF+1];

  // leading one position, zero treated as one
  always_comb begin
    p_d = 5'd0;
    for (int k = 0; k < 32; k++) begin
      if (mag_i[k]) begin
        p_d = 5'(k);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q  <= (mag_i == 32'd0) ? 32'd1 : mag_i;
      pa_q <= p_d;
      // normalize to q1.31
      y_q[0]    <= m_q << (5'd31 - pa_q);
      pp_q[0]   <= pa_q;
      bits_q[0] <= '0;
    end
  end

  for (genvar r = 0; r < LF; r++) begin : g_round
    logic [63:0] sq;
    logic [32:0] t;
    assign sq = {32'd0, y_q[r]} * {32'd0, y_q[r]};
    assign t  = sq[63:31];
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        bits_q[r+1] <= {bits_q[r][LF-2:0], t[32]};
        pp_q[r+1]   <= pp_q[r];
      end
    end
    if (r < LF - 1) begin : g_y
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          y_q[r+1] <= t[32] ? t[32:1] : t[31:0];
        end
      end
    end
  end

  assign log_o = {pp_q[LF], bits_q[LF]};

endmodule
`default_nettype wire

// ===== rtl/log_scaled_color_map_top.sv =====
// log-scaled color lookup, one beat in and at most one beat out per cycle
// the pipeline runs input capture, range check, log2 lanes with their squaring rounds,
// log differences, scaling, the radix-2 divider, final index, then the table read and result
// throughput: one beat per cycle; the whole pipeline holds while a result is stalled
// reset: async active low, clears valids and loads the range and count registers;
// the color table is not cleared and holds garbage until written
`default_nettype none
module log_scaled_color_map_top
  import lscm_pkg::*;
#(
  parameter int TABLE_DEPTH   = DEF_TABLE_DEPTH,
  parameter int SAMPLE_WIDTH  = DEF_SAMPLE_WIDTH,
  parameter int LOG_FRAC_BITS = DEF_LOG_FRAC_BITS
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  // input channel
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic                    mode_i,
  input  wire logic [SAMPLE_WIDTH-1:0] sample_i,
  input  wire logic [7:0]              entry_index_i,
  input  wire logic [31:0]             entry_color_i,
  input  wire logic                    last_sample_i,
  // result channel
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic      [31:0]             rgba_o,
  output logic      [7:0]              color_index_o,
  output logic                         range_error_o,
  output logic                         last_o,
  // configuration
  input  wire logic                    cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire logic [1:0]              cfg_index_i,
  input  wire logic [31:0]             cfg_data_i
);

  localparam int SW     = SAMPLE_WIDTH;
  localparam int IW     = $clog2(TABLE_DEPTH);
  localparam int LW     = LOG_FRAC_BITS + 5;
  localparam int PW     = LW + IW;
  localparam int LOGLAT = LOG_FRAC_BITS + 2;

  // side data that travels along with each beat
  typedef struct packed {
    logic          mode;
    logic          last;
    logic          err;
    logic          neg;
    logic [IW-1:0] cm1;
    logic [7:0]    eidx;
    logic [31:0]   color;
  } side_t;

  // ---------------- configuration registers
  logic [31:0] min_q, max_q;
  logic [8:0]  cnt_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= RST_RANGE_MIN;
      max_q <= RST_RANGE_MAX;
      cnt_q <= RST_COLOR_COUNT;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_RANGE_MIN:   min_q <= cfg_data_i;
        REG_RANGE_MAX:   max_q <= cfg_data_i;
        REG_COLOR_COUNT: cnt_q <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  // ---------------- global advance: everything moves unless a result is held
  logic en;
  logic out_valid_q;

  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  // ---------------- stage 0: input capture
  logic          s0_vld_q;
  logic          s0_mode_q, s0_last_q;
  logic [SW-1:0] s0_sample_q;
  logic [7:0]    s0_eidx_q;
  logic [31:0]   s0_color_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else if (en) begin
      s0_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_mode_q   <= mode_i;
      s0_last_q   <= last_sample_i;
      s0_sample_q <= sample_i;
      s0_eidx_q   <= entry_index_i;
      s0_color_q  <= entry_color_i;
    end
  end

  // ---------------- stage 1: range check, clamp, magnitudes
  logic signed [SW:0] lo_s, hi_s, v_s, vc_s;
  logic signed [SW:0] mv_s, mlo_s, mhi_s;
  logic               err_d, neg_d;
  logic [IW-1:0]      cm1_d;
  side_t              s1_d;

  always_comb begin
    lo_s  = signed'({min_q[SW-1], min_q[SW-1:0]});
    hi_s  = signed'({max_q[SW-1], max_q[SW-1:0]});
    v_s   = signed'({s0_sample_q[SW-1], s0_sample_q});
    // empty range or one that holds zero
    err_d = (lo_s >= hi_s) || (!hi_s[SW] && (lo_s[SW] || lo_s == '0));
    neg_d = hi_s[SW];
    vc_s  = v_s;
    if (vc_s < lo_s) vc_s = lo_s;
    if (vc_s > hi_s) vc_s = hi_s;
    mv_s  = neg_d ? -vc_s : vc_s;
    mlo_s = neg_d ? -lo_s : lo_s;
    mhi_s = neg_d ? -hi_s : hi_s;
    if (cnt_q == 9'd0) begin
      cm1_d = '0;
    end else if (13'(cnt_q) > 13'(TABLE_DEPTH)) begin
      cm1_d = IW'(TABLE_DEPTH - 1);
    end else begin
      cm1_d = IW'(cnt_q - 9'd1);
    end
    s1_d.mode  = s0_mode_q;
    s1_d.last  = s0_last_q;
    s1_d.err   = err_d;
    s1_d.neg   = neg_d;
    s1_d.cm1   = cm1_d;
    s1_d.eidx  = s0_eidx_q;
    s1_d.color = s0_color_q;
  end

  logic        s1_vld_q;
  side_t       s1_q;
  logic [31:0] mv_q, mlo_q, mhi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= s0_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q  <= s1_d;
      mv_q  <= 32'(mv_s[SW-1:0]);
      mlo_q <= 32'(mlo_s[SW-1:0]);
      mhi_q <= 32'(mhi_s[SW-1:0]);
    end
  end

  // ---------------- log2 lanes: sample, lower bound, upper bound
  logic [LW-1:0] lv, llo, lhi;

  lscm_log #(.LOG_FRAC_BITS(LOG_FRAC_BITS)) u_log_v (
    .clk_i, .en_i(en), .mag_i(mv_q), .log_o(lv)
  );
  lscm_log #(.LOG_FRAC_BITS(LOG_FRAC_BITS)) u_log_lo (
    .clk_i, .en_i(en), .mag_i(mlo_q), .log_o(llo)
  );
  lscm_log #(.LOG_FRAC_BITS(LOG_FRAC_BITS)) u_log_hi (
    .clk_i, .en_i(en), .mag_i(mhi_q), .log_o(lhi)
  );

  logic  lg_vld_q [LOGLAT];
  side_t lg_q     [LOGLAT];

  for (genvar k = 0; k < LOGLAT; k++) begin : g_lgside
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        lg_vld_q[k] <= 1'b0;
      end else if (en) begin
        lg_vld_q[k] <= (k == 0) ? s1_vld_q : lg_vld_q[(k == 0) ? 0 : k-1];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        lg_q[k] <= (k == 0) ? s1_q : lg_q[(k == 0) ? 0 : k-1];
      end
    end
  end

  // ---------------- d1: log differences
  logic [LW-1:0] num_d, den_d;

  always_comb begin
    if (lg_q[LOGLAT-1].neg) begin
      num_d = (llo >= lv)  ? llo - lv  : '0;
      den_d = (llo >= lhi) ? llo - lhi : '0;
    end else begin
      num_d = (lv >= llo)  ? lv - llo  : '0;
      den_d = (lhi >= llo) ? lhi - llo : '0;
    end
  end

  logic          d1_vld_q;
  side_t         d1_q;
  logic [LW-1:0] d1_num_q, d1_den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d1_vld_q <= 1'b0;
    end else if (en) begin
      d1_vld_q <= lg_vld_q[LOGLAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d1_q     <= lg_q[LOGLAT-1];
      d1_num_q <= num_d;
      d1_den_q <= den_d;
    end
  end

  // ---------------- d2: scale by colors-1, flag saturation and zero span
  logic          dv_vld_q [IW+1];
  side_t         dv_q     [IW+1];
  logic [PW-1:0] rem_q    [IW+1];
  logic [IW-1:0] quo_q    [IW+1];
  logic [LW-1:0] den_q    [IW+1];
  logic          sat_q    [IW+1];
  logic          zro_q    [IW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_vld_q[0] <= 1'b0;
    end else if (en) begin
      dv_vld_q[0] <= d1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_q[0]  <= d1_q;
      rem_q[0] <= PW'(d1_num_q) * PW'(d1_q.cm1);
      quo_q[0] <= '0;
      den_q[0] <= d1_den_q;
      // num at or above den gives at least colors-1
      sat_q[0] <= (d1_num_q >= d1_den_q);
      zro_q[0] <= (d1_den_q == '0);
    end
  end

  // restoring divider, one quotient bit per stage, msb first
  for (genvar j = 0; j < IW; j++) begin : g_div
    localparam int B = IW - 1 - j;
    logic [PW-1:0] dsh;
    logic          take;
    assign dsh  = PW'(den_q[j]) << B;
    assign take = (rem_q[j] >= dsh);
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[j+1] <= 1'b0;
      end else if (en) begin
        dv_vld_q[j+1] <= dv_vld_q[j];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_q[j+1]  <= dv_q[j];
        rem_q[j+1] <= take ? rem_q[j] - dsh : rem_q[j];
        quo_q[j+1] <= quo_q[j] | (take ? (IW'(1) << B) : '0);
        den_q[j+1] <= den_q[j];
        sat_q[j+1] <= sat_q[j];
        zro_q[j+1] <= zro_q[j];
      end
    end
  end

  // ---------------- final index
  logic [IW-1:0] idx_d;

  always_comb begin
    if (dv_q[IW].err || zro_q[IW]) begin
      idx_d = '0;
    end else if (sat_q[IW] || quo_q[IW] > dv_q[IW].cm1) begin
      idx_d = dv_q[IW].cm1;
    end else begin
      idx_d = quo_q[IW];
    end
  end

  logic          f_vld_q;
  side_t         f_q;
  logic [IW-1:0] f_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q <= 1'b0;
    end else if (en) begin
      f_vld_q <= dv_vld_q[IW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_q     <= dv_q[IW];
      f_idx_q <= idx_d;
    end
  end

  // ---------------- table access: writes and reads stay in beat order here
  logic          ram_we;
  logic [IW-1:0] ram_addr;
  logic [31:0]   eidx_w;
  logic [31:0]   idx_w;

  assign eidx_w   = 32'(f_q.eidx);
  assign ram_we   = en && f_vld_q && !f_q.mode && (eidx_w < 32'(TABLE_DEPTH));
  assign ram_addr = f_q.mode ? f_idx_q : IW'(f_q.eidx);

  lscm_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_table (
    .clk_i,
    .we_i   (ram_we),
    .re_i   (en),
    .addr_i (ram_addr),
    .wdata_i(f_q.color),
    .rdata_o(rgba_o)
  );

  // result register, side by side with the table read data
  logic [7:0] cidx_q;
  logic       err_q, last_q;

  assign idx_w = 32'(f_idx_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= f_vld_q && f_q.mode;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cidx_q <= idx_w[7:0];
      err_q  <= f_q.err;
      last_q <= f_q.last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign color_index_o = cidx_q;
  assign range_error_o = err_q;
  assign last_o        = last_q;

endmodule
`default_nettype wire

// ===== rtl/lscm_checker.sv =====
`default_nettype none
module lscm_checker #(
  parameter int SAMPLE_WIDTH = 32
) (
  input wire logic                    clk_i,
  input wire logic                    rst_ni,
  input wire logic                    in_valid_i,
  input wire logic                    in_stall_o,
  input wire logic                    mode_i,
  input wire logic [SAMPLE_WIDTH-1:0] sample_i,
  input wire logic [7:0]              entry_index_i,
  input wire logic [31:0]             entry_color_i,
  input wire logic                    last_sample_i,
  input wire logic                    out_valid_o,
  input wire logic                    out_stall_i,
  input wire logic [31:0]             rgba_o,
  input wire logic [7:0]              color_index_o,
  input wire logic                    range_error_o,
  input wire logic                    last_o,
  input wire logic                    cfg_valid_i,
  input wire logic                    cfg_ready_o,
  input wire logic [1:0]              cfg_index_i,
  input wire logic [31:0]             cfg_data_i
);

  // a held result beat stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(rgba_o) && $stable(color_index_o)
      && $stable(range_error_o) && $stable(last_o))
    else $error("result payload changed while stalled");

  // a bad range always maps to the first color
  a_err_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && range_error_o |-> color_index_o == 8'd0)
    else $error("range error with nonzero index");

  // input backpressure only comes from a held result
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a held result");

endmodule

bind log_scaled_color_map_top lscm_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_lscm_checker (.*);
`default_nettype wire

// ===== sim/log_scaled_color_map_checker.sv =====
`default_nettype none
module log_scaled_color_map_checker
  import lscm_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_stall_i,
  input  wire logic        mode_i,
  input  wire logic [31:0] sample_i,
  input  wire logic [7:0]  entry_index_i,
  input  wire logic [31:0] entry_color_i,
  input  wire logic        last_sample_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_stall_i,
  input  wire logic [31:0] rgba_i,
  input  wire logic [7:0]  color_index_i,
  input  wire logic        range_error_i,
  input  wire logic        last_i,
  input  wire logic        cfg_valid_i,
  input  wire logic        cfg_ready_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  output int               fail_count_o,
  output int               pending_o,
  output logic             beat_seen_o
);

  typedef struct packed {
    logic [31:0] rgba;
    logic [7:0]  color_index;
    logic        range_error;
    logic        last;
  } color_beat_t;

  logic [31:0] palette [256];
  logic [31:0] lo_reg, hi_reg;
  logic [8:0]  count_reg;
  color_beat_t color_q[$];

  // leading-one position plus squaring rounds
  function automatic logic [63:0] log2_q16(logic [63:0] m);
    int p;
    logic [63:0] y, bits;
    p = 0;
    bits = 0;
    if (m == 0) m = 1;
    for (int k = 0; k < 32; k++) if (m[k]) p = k;
    y = (m << (31 - p)) & 64'hFFFF_FFFF;
    for (int k = 0; k < 16; k++) begin
      y = (y * y) >> 31;
      bits = bits << 1;
      if (y >= 64'h1_0000_0000) begin
        bits[0] = 1'b1;
        y = y >> 1;
      end
    end
    return (64'(p) << 16) | bits;
  endfunction

  function automatic color_beat_t map_sample(logic signed [31:0] s, logic lst);
    longint lo, hi, v;
    logic [63:0] lv, llo, lhi, num, den, idx, colors;
    color_beat_t r;
    lo = longint'($signed(lo_reg));
    hi = longint'($signed(hi_reg));
    v = longint'(s);
    colors = count_reg;
    if (colors < 1) colors = 1;
    if (colors > 256) colors = 256;
    idx = 0;
    r.range_error = 1'b0;
    if (lo >= hi || (hi >= 0 && lo <= 0)) begin
      r.range_error = 1'b1;
    end else begin
      if (v < lo) v = lo;
      if (v > hi) v = hi;
      if (hi < 0) begin
        lv = log2_q16(-v); llo = log2_q16(-lo); lhi = log2_q16(-hi);
        num = (llo >= lv) ? llo - lv : 0;
        den = (llo >= lhi) ? llo - lhi : 0;
      end else begin
        lv = log2_q16(v); llo = log2_q16(lo); lhi = log2_q16(hi);
        num = (lv >= llo) ? lv - llo : 0;
        den = (lhi >= llo) ? lhi - llo : 0;
      end
      if (den != 0) idx = (num * (colors - 1)) / den;
      if (idx > colors - 1) idx = colors - 1;
    end
    r.color_index = idx[7:0];
    r.rgba = palette[idx[7:0]];
    r.last = lst;
    return r;
  endfunction

  assign pending_o = color_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    color_beat_t got, want;
    if (!rst_ni) begin
      lo_reg <= RST_RANGE_MIN;
      hi_reg <= RST_RANGE_MAX;
      count_reg <= RST_COLOR_COUNT;
      fail_count_o <= 0;
      beat_seen_o <= 1'b0;
      color_q.delete();
    end else begin
      beat_seen_o <= (in_valid_i && !in_stall_i) || (out_valid_i && !out_stall_i)
                     || (cfg_valid_i && cfg_ready_i);
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_RANGE_MIN:   lo_reg <= cfg_data_i;
          REG_RANGE_MAX:   hi_reg <= cfg_data_i;
          REG_COLOR_COUNT: count_reg <= cfg_data_i[8:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        if (!mode_i) palette[entry_index_i] = entry_color_i;
        else color_q.push_back(map_sample(sample_i, last_sample_i));
      end
      if (out_valid_i && !out_stall_i) begin
        got = '{rgba_i, color_index_i, range_error_i, last_i};
        if (color_q.size() == 0) begin
          $error("unexpected result beat rgba=%h", rgba_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = color_q.pop_front();
          if (got != want) begin
            fail_count_o <= fail_count_o + 1;
            if (got.rgba != want.rgba)
              $error("rgba exp %h got %h", want.rgba, got.rgba);
            if (got.color_index != want.color_index)
              $error("color_index exp %0d got %0d", want.color_index, got.color_index);
            if (got.range_error != want.range_error)
              $error("range_error exp %0d got %0d", want.range_error, got.range_error);
            if (got.last != want.last)
              $error("last exp %0d got %0d", want.last, got.last);
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== sim/log_scaled_color_map_top_test.sv =====
`default_nettype none
module log_scaled_color_map_top_test;
  import lscm_pkg::*;

  localparam int LATENCY = 40;
  localparam int WATCHDOG = 20000;

  logic        clk, rst_n;
  logic        in_valid, in_stall, mode, last_sample;
  logic [31:0] sample, entry_color;
  logic [7:0]  entry_index;
  logic        out_valid, out_stall, range_error, last;
  logic [31:0] rgba;
  logic [7:0]  color_index;
  logic        cfg_valid, cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;
  int          fail_count, pending;
  logic        beat_seen;

  // stall shaping: random bursts, a long hold-off on request, none at the end
  logic quiet_tail;
  logic hold_off;
  int   idle_cycles;

  log_scaled_color_map_top dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .mode_i(mode),
    .sample_i(sample), .entry_index_i(entry_index), .entry_color_i(entry_color),
    .last_sample_i(last_sample),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .rgba_o(rgba),
    .color_index_o(color_index), .range_error_o(range_error), .last_o(last),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_index_i(cfg_index),
    .cfg_data_i(cfg_data)
  );

  log_scaled_color_map_checker chk (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .mode_i(mode),
    .sample_i(sample), .entry_index_i(entry_index), .entry_color_i(entry_color),
    .last_sample_i(last_sample),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .rgba_i(rgba),
    .color_index_i(color_index), .range_error_i(range_error), .last_i(last),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready), .cfg_index_i(cfg_index),
    .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending), .beat_seen_o(beat_seen)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // receiver side stall, in its own process
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
        out_stall <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles without any accepted beat
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if (beat_seen) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // one beat on the input channel, with an optional random gap ahead of it
  task automatic send_beat(logic m, logic [31:0] s, logic [7:0] ei, logic [31:0] ec,
                           logic ls);
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m; sample <= s; entry_index <= ei; entry_color <= ec;
    last_sample <= ls;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic end_burst();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_e r, logic [31:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // wait for all results, then let in-flight table writes settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic fill_palette();
    for (int i = 0; i < 256; i++)
      send_beat(1'b0, $urandom, i[7:0], $urandom, 1'($urandom));
  endtask

  // sample biased toward the configured range and its edges
  function automatic logic [31:0] pick_sample(logic [31:0] lo, logic [31:0] hi);
    case ($urandom_range(0, 5))
      0: return lo;
      1: return hi;
      2: return $urandom;
      3: return lo + $urandom_range(0, 40);
      4: return hi - $urandom_range(0, 40);
      default: return $signed(lo) + $urandom_range(0, 1000000);
    endcase
  endfunction

  logic [31:0] lo_set [8];
  logic [31:0] hi_set [8];

  initial begin
    in_valid = 1'b0; mode = 1'b0; sample = '0; entry_index = '0;
    entry_color = '0; last_sample = 1'b0;
    cfg_valid = 1'b0; cfg_index = REG_RANGE_MIN; cfg_data = '0;
    quiet_tail = 1'b0; hold_off = 1'b0;
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: fill table, then reset-default range
    fill_palette();
    send_beat(1'b0, '0, 8'd0, 32'hFFFF_FFFF, 1'b0);
    send_beat(1'b0, '0, 8'd255, 32'h0000_0000, 1'b1);
    send_beat(1'b1, 32'd1, '0, '0, 1'b0);
    send_beat(1'b1, 32'd10, '0, '0, 1'b1);
    send_beat(1'b1, 32'h8000_0000, '0, '0, 1'b0);
    send_beat(1'b1, 32'h7FFF_FFFF, '0, '0, 1'b1);
    send_beat(1'b1, 32'd5, '0, '0, 1'b0);
    drain();
    // negative range, full extremes
    write_reg(REG_RANGE_MIN, 32'h8000_0000);
    write_reg(REG_RANGE_MAX, 32'hFFFF_FFFF);
    send_beat(1'b1, 32'h8000_0000, '0, '0, 1'b0);
    send_beat(1'b1, 32'hFFFF_FFFF, '0, '0, 1'b1);
    send_beat(1'b1, 32'hFFFF_0000, '0, '0, 1'b0);
    send_beat(1'b1, 32'h7FFF_FFFF, '0, '0, 1'b0);
    drain();
    // range spanning zero, and min not below max
    write_reg(REG_RANGE_MAX, 32'd5);
    send_beat(1'b1, 32'd3, '0, '0, 1'b1);
    drain();
    write_reg(REG_RANGE_MIN, 32'd9);
    write_reg(REG_RANGE_MAX, 32'd9);
    send_beat(1'b1, 32'd9, '0, '0, 1'b0);
    drain();
    // narrow range at count 0, then count above depth
    write_reg(REG_RANGE_MIN, 32'd8);
    write_reg(REG_RANGE_MAX, 32'd9);
    write_reg(REG_COLOR_COUNT, 32'd0);
    send_beat(1'b1, 32'd9, '0, '0, 1'b0);
    drain();
    write_reg(REG_COLOR_COUNT, 32'h1FF);
    write_reg(REG_RANGE_MIN, 32'd1);
    write_reg(REG_RANGE_MAX, 32'h7FFF_FFFF);
    send_beat(1'b1, 32'h7FFF_FFFF, '0, '0, 1'b1);
    send_beat(1'b1, 32'd2, '0, '0, 1'b0);
    drain();

    lo_set = '{32'd1, 32'd1, 32'd100, 32'h8000_0000, 32'hFFFF_FC00,
               32'd3, 32'hFFFF_0000, 32'd0};
    hi_set = '{32'd10, 32'h7FFF_FFFF, 32'd100000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
               32'd4, 32'd65535, 32'd0};

    // random phases, each with its own setting
    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 11) quiet_tail = 1'b1;
      if (ph < 8) begin
        write_reg(REG_RANGE_MIN, lo_set[ph]);
        write_reg(REG_RANGE_MAX, hi_set[ph]);
      end else begin
        write_reg(REG_RANGE_MIN, $urandom);
        write_reg(REG_RANGE_MAX, $urandom);
      end
      write_reg(REG_COLOR_COUNT,
                (ph % 3 == 0) ? 32'd256 : 32'($urandom_range(1, 300)));
      if (ph == 4) hold_off = 1'b1;
      for (int n = 0; n < 100; n++) begin
        if ($urandom_range(0, 5) == 0)
          send_beat(1'b0, $urandom, 8'($urandom), $urandom, 1'($urandom));
        else
          send_beat(1'b1, pick_sample(chk.lo_reg, chk.hi_reg), 8'($urandom), $urandom,
                    1'($urandom));
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== log_scaled_color_map_top.f =====
rtl/lscm_pkg.sv
rtl/lscm_ram.sv
rtl/lscm_log.sv
rtl/log_scaled_color_map_top.sv
rtl/lscm_checker.sv
sim/log_scaled_color_map_checker.sv
sim/log_scaled_color_map_top_test.sv
